/* hw/rtl/sha1sh_pkg.sv */
`default_nettype none

package sha1sh_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned BlockBits  = 512;
   localparam int unsigned LenWidth   = 64;
   localparam int unsigned FillWidth  = 6;
   localparam int unsigned RoundWidth = 7;
   localparam int unsigned NumRounds  = 80;

   localparam logic [WordWidth-1:0] IV0 = 32'h6745_2301;
   localparam logic [WordWidth-1:0] IV1 = 32'hEFCD_AB89;
   localparam logic [WordWidth-1:0] IV2 = 32'h98BA_DCFE;
   localparam logic [WordWidth-1:0] IV3 = 32'h1032_5476;
   localparam logic [WordWidth-1:0] IV4 = 32'hC3D2_E1F0;

   localparam logic [WordWidth-1:0] K0 = 32'h5A82_7999;
   localparam logic [WordWidth-1:0] K1 = 32'h6ED9_EBA1;
   localparam logic [WordWidth-1:0] K2 = 32'h8F1B_BCDC;
   localparam logic [WordWidth-1:0] K3 = 32'hCA62_C1D6;

   localparam logic [7:0] PadByte  = 8'h80;
   localparam logic [7:0] ZeroByte = 8'h00;

   localparam logic [FillWidth-1:0]  FillLast   = 6'd63;
   localparam logic [FillWidth-1:0]  FillLength = 6'd56;
   localparam logic [RoundWidth-1:0] RoundLast  = 7'd79;
   localparam logic [RoundWidth-1:0] RoundK1    = 7'd20;
   localparam logic [RoundWidth-1:0] RoundK2    = 7'd40;
   localparam logic [RoundWidth-1:0] RoundK3    = 7'd60;
   localparam logic [LenWidth-1:0]   BitsPerByte = 64'd8;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [63:0] digest_high;
      logic [63:0] digest_mid;
      logic [31:0] digest_low;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_PAD    = 5'b00010,
      ST_ROUND  = 5'b00100,
      ST_UPDATE = 5'b01000,
      ST_OUT    = 5'b10000
   } state_type;

   function automatic logic [WordWidth-1:0] rol(input logic [WordWidth-1:0] v,
                                                input int unsigned n);
      rol = (v << n) | (v >> (WordWidth - n));
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/sha1_stream_hash_core.sv */
// SHA-1 digest of a byte stream.
// Request channel (req_valid / req_stall / req_data): one transaction per
// message byte; byte_valid = 0 carries no byte, last = 1 ends the message.
// Response channel (rsp_valid / rsp_stall / rsp_data): one transaction per
// message, the 160-bit digest split into digest_high, digest_mid, digest_low.
// A byte that does not complete a 64-byte block is simply shifted in. A
// byte that completes a block starts a compression: one shared round unit
// runs the 80 rounds one per cycle, then the UPDATE state adds into the
// chaining words. On last, padding shifts in one byte per cycle up to byte
// 56 of the block, loads the length, and runs one or two compressions.
// req_stall is high whenever the block is busy or holds a digest.
// The digest holds on rsp_data while rsp_stall is high; once taken, the
// block returns to the initial chaining state for the next message.
// Reset (synchronous) clears the length and fill count, restores the initial
// chaining words and drops any message in progress.
`default_nettype none

module sha1_stream_hash_core (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire sha1sh_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output sha1sh_pkg::rsp_type   rsp_data
);

   localparam int unsigned W  = sha1sh_pkg::WordWidth;
   localparam int unsigned BB = sha1sh_pkg::BlockBits;

   sha1sh_pkg::state_type                  state_ff, state_in;
   logic [sha1sh_pkg::FillWidth-1:0]       fill_ff, fill_in;
   logic [sha1sh_pkg::LenWidth-1:0]        bits_ff, bits_in;
   logic [sha1sh_pkg::RoundWidth-1:0]      rnd_ff, rnd_in;
   logic                                   last_ff, last_in;
   logic                                   pad80_ff, pad80_in;
   logic                                   final_ff, final_in;
   logic [W-1:0]                           h0_ff, h1_ff, h2_ff, h3_ff, h4_ff;
   logic [W-1:0]                           h0_in, h1_in, h2_in, h3_in, h4_in;
   logic [W-1:0]                           a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [W-1:0]                           a_in, b_in, c_in, d_in, e_in;
   logic [BB-1:0]                          blk_ff, blk_in;

   logic         req_take;
   logic         start_round;
   logic [7:0]   pad_byte;
   logic [W-1:0] w0, w2, w8, w13, w_next;
   logic [W-1:0] f_val, k_val, t_val;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != sha1sh_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == sha1sh_pkg::ST_OUT);

   assign rsp_data.digest_high = {h0_ff, h1_ff};
   assign rsp_data.digest_mid  = {h2_ff, h3_ff};
   assign rsp_data.digest_low  = h4_ff;

   assign w0     = blk_ff[BB-1       -: W];
   assign w2     = blk_ff[BB-1-2*W   -: W];
   assign w8     = blk_ff[BB-1-8*W   -: W];
   assign w13    = blk_ff[BB-1-13*W  -: W];
   assign w_next = sha1sh_pkg::rol(w13 ^ w8 ^ w2 ^ w0, 1);

   assign pad_byte = pad80_ff ? sha1sh_pkg::PadByte : sha1sh_pkg::ZeroByte;

   always_comb begin
      if (rnd_ff < sha1sh_pkg::RoundK1) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = sha1sh_pkg::K0;
      end else if (rnd_ff < sha1sh_pkg::RoundK2) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = sha1sh_pkg::K1;
      end else if (rnd_ff < sha1sh_pkg::RoundK3) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = sha1sh_pkg::K2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = sha1sh_pkg::K3;
      end
   end

   assign t_val = sha1sh_pkg::rol(a_ff, 5) + f_val + e_ff + k_val + w0;

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      bits_in     = bits_ff;
      rnd_in      = rnd_ff;
      last_in     = last_ff;
      pad80_in    = pad80_ff;
      final_in    = final_ff;
      h0_in       = h0_ff;
      h1_in       = h1_ff;
      h2_in       = h2_ff;
      h3_in       = h3_ff;
      h4_in       = h4_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      c_in        = c_ff;
      d_in        = d_ff;
      e_in        = e_ff;
      blk_in      = blk_ff;
      start_round = 1'b0;

      case (state_ff)
         sha1sh_pkg::ST_IDLE: begin
            if (req_take) begin
               last_in  = req_data.last;
               pad80_in = 1'b1;
               final_in = 1'b0;
               if (req_data.byte_valid) begin
                  blk_in  = {blk_ff[BB-9:0], req_data.data_byte};
                  bits_in = bits_ff + sha1sh_pkg::BitsPerByte;
                  fill_in = fill_ff + 1'b1;
                  if (fill_ff == sha1sh_pkg::FillLast) begin
                     start_round = 1'b1;
                  end else if (req_data.last) begin
                     state_in = sha1sh_pkg::ST_PAD;
                  end
               end else if (req_data.last) begin
                  state_in = sha1sh_pkg::ST_PAD;
               end
            end
         end
         sha1sh_pkg::ST_PAD: begin
            if (!pad80_ff && fill_ff == sha1sh_pkg::FillLength) begin
               blk_in      = {blk_ff[BB-sha1sh_pkg::LenWidth-1:0], bits_ff};
               fill_in     = '0;
               final_in    = 1'b1;
               start_round = 1'b1;
            end else begin
               blk_in   = {blk_ff[BB-9:0], pad_byte};
               pad80_in = 1'b0;
               fill_in  = fill_ff + 1'b1;
               if (fill_ff == sha1sh_pkg::FillLast) begin
                  start_round = 1'b1;
               end
            end
         end
         sha1sh_pkg::ST_ROUND: begin
            e_in   = d_ff;
            d_in   = c_ff;
            c_in   = sha1sh_pkg::rol(b_ff, 30);
            b_in   = a_ff;
            a_in   = t_val;
            blk_in = {blk_ff[BB-W-1:0], w_next};
            rnd_in = rnd_ff + 1'b1;
            if (rnd_ff == sha1sh_pkg::RoundLast) begin
               state_in = sha1sh_pkg::ST_UPDATE;
            end
         end
         sha1sh_pkg::ST_UPDATE: begin
            h0_in = h0_ff + a_ff;
            h1_in = h1_ff + b_ff;
            h2_in = h2_ff + c_ff;
            h3_in = h3_ff + d_ff;
            h4_in = h4_ff + e_ff;
            if (final_ff) begin
               state_in = sha1sh_pkg::ST_OUT;
            end else if (last_ff) begin
               state_in = sha1sh_pkg::ST_PAD;
            end else begin
               state_in = sha1sh_pkg::ST_IDLE;
            end
         end
         sha1sh_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               h0_in    = sha1sh_pkg::IV0;
               h1_in    = sha1sh_pkg::IV1;
               h2_in    = sha1sh_pkg::IV2;
               h3_in    = sha1sh_pkg::IV3;
               h4_in    = sha1sh_pkg::IV4;
               fill_in  = '0;
               bits_in  = '0;
               last_in  = 1'b0;
               final_in = 1'b0;
               state_in = sha1sh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sha1sh_pkg::ST_IDLE;
         end
      endcase

      if (start_round) begin
         a_in     = h0_ff;
         b_in     = h1_ff;
         c_in     = h2_ff;
         d_in     = h3_ff;
         e_in     = h4_ff;
         rnd_in   = '0;
         state_in = sha1sh_pkg::ST_ROUND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha1sh_pkg::ST_IDLE;
         fill_ff  <= '0;
         bits_ff  <= '0;
         rnd_ff   <= '0;
         last_ff  <= 1'b0;
         pad80_ff <= 1'b0;
         final_ff <= 1'b0;
         h0_ff    <= sha1sh_pkg::IV0;
         h1_ff    <= sha1sh_pkg::IV1;
         h2_ff    <= sha1sh_pkg::IV2;
         h3_ff    <= sha1sh_pkg::IV3;
         h4_ff    <= sha1sh_pkg::IV4;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
         rnd_ff   <= rnd_in;
         last_ff  <= last_in;
         pad80_ff <= pad80_in;
         final_ff <= final_in;
         h0_ff    <= h0_in;
         h1_ff    <= h1_in;
         h2_ff    <= h2_in;
         h3_ff    <= h3_in;
         h4_ff    <= h4_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
      blk_ff <= blk_in;
   end

endmodule

`default_nettype wire

/* test/tb_sha1_stream_hash_core.sv */
`default_nettype none

module tb_sha1_stream_hash_core;

   timeunit 1ns;
   timeprecision 1ps;

   class sha1_digest_board;
      bit [31:0] chain_word [5];
      bit [31:0] msg_word [16];
      bit [5:0]  byte_count;
      bit [63:0] length_bits;
      sha1sh_pkg::rsp_type expected_digests [$];
      int        mismatches;

      function new();
         mismatches = 0;
         start_message();
      endfunction

      function void start_message();
         chain_word = '{sha1sh_pkg::IV0, sha1sh_pkg::IV1, sha1sh_pkg::IV2,
                        sha1sh_pkg::IV3, sha1sh_pkg::IV4};
         foreach (msg_word[i]) msg_word[i] = '0;
         byte_count = '0;
         length_bits = '0;
      endfunction

      function int pending();
         return expected_digests.size();
      endfunction

      function void place_byte(int pos, bit [7:0] value);
         msg_word[pos / 4][8 * (3 - pos % 4) +: 8] = value;
      endfunction

      function void run_rounds();
         bit [31:0] w [16];
         bit [31:0] a, b, c, d, e, f, k, t, x;
         w = msg_word;
         a = chain_word[0];
         b = chain_word[1];
         c = chain_word[2];
         d = chain_word[3];
         e = chain_word[4];
         for (int r = 0; r < 80; r++) begin
            if (r >= 16) begin
               x = w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16];
               w[r % 16] = {x[30:0], x[31]};
            end
            if (r < 20) begin
               f = (b & c) | (~b & d);
               k = sha1sh_pkg::K0;
            end else if (r < 40) begin
               f = b ^ c ^ d;
               k = sha1sh_pkg::K1;
            end else if (r < 60) begin
               f = (b & c) | (b & d) | (c & d);
               k = sha1sh_pkg::K2;
            end else begin
               f = b ^ c ^ d;
               k = sha1sh_pkg::K3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[r % 16];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
         end
         chain_word[0] += a;
         chain_word[1] += b;
         chain_word[2] += c;
         chain_word[3] += d;
         chain_word[4] += e;
      endfunction

      function void take_request(sha1sh_pkg::req_type item);
         sha1sh_pkg::rsp_type digest;
         if (item.byte_valid) begin
            place_byte(byte_count, item.data_byte);
            length_bits += 64'd8;
            byte_count += 6'd1;
            if (byte_count == 6'd0) run_rounds();
         end
         if (!item.last) return;
         place_byte(byte_count, sha1sh_pkg::PadByte);
         for (int p = int'(byte_count) + 1; p < 64; p++) place_byte(p, 8'h00);
         if (byte_count >= sha1sh_pkg::FillLength) begin
            run_rounds();
            foreach (msg_word[i]) msg_word[i] = '0;
         end
         msg_word[14] = length_bits[63:32];
         msg_word[15] = length_bits[31:0];
         run_rounds();
         digest.digest_high = {chain_word[0], chain_word[1]};
         digest.digest_mid  = {chain_word[2], chain_word[3]};
         digest.digest_low  = chain_word[4];
         expected_digests = {expected_digests, digest};
         start_message();
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
         mismatches++;
      endtask

      task check_digest(sha1sh_pkg::rsp_type got);
         sha1sh_pkg::rsp_type want;
         if (expected_digests.size() == 0) begin
            report("unexpected digest", got.digest_high, 64'd0);
            return;
         end
         want = expected_digests.pop_front();
         if (got.digest_high !== want.digest_high)
            report("digest_high", got.digest_high, want.digest_high);
         if (got.digest_mid !== want.digest_mid)
            report("digest_mid", got.digest_mid, want.digest_mid);
         if (got.digest_low !== want.digest_low)
            report("digest_low", {32'd0, got.digest_low}, {32'd0, want.digest_low});
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   sha1sh_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   sha1sh_pkg::rsp_type rsp_data;

   sha1_digest_board board;
   int burst_left;
   int sent_items = 0;

   sha1_stream_hash_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   task automatic idle_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      req_data  <= {8'($urandom_range(255, 0)), 2'($urandom_range(3, 0))};
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic send_item(input logic [7:0] value, input logic has_byte, input logic ends);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= {value, has_byte, ends};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.take_request(req_data);
      sent_items++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(300, 50)
                                                  : $urandom_range(24, 1);
         idle_sender($urandom_range(12, 1));
      end
   endtask

   task automatic drain_results();
      idle_sender(1);
      while (board.pending() != 0) @(negedge clock);
   endtask

   task automatic send_message(input int len, input bit split_end);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(19, 0) == 0) send_item(8'($urandom_range(255, 0)), 1'b0, 1'b0);
         send_item(8'($urandom_range(255, 0)), 1'b1, (i == len - 1) && !split_end);
      end
      if (split_end || len == 0) send_item(8'($urandom_range(255, 0)), 1'b0, 1'b1);
   endtask

   function automatic int pick_length();
      case ($urandom_range(9, 0))
         0, 1, 2, 3, 4: return $urandom_range(8, 0);
         5, 6, 7:       return 64 * $urandom_range(1, 0) + 54 + $urandom_range(11, 0);
         default:       return $urandom_range(100, 9);
      endcase
   endfunction

   initial begin : stimulus
      board = new();
      burst_left = $urandom_range(24, 1);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'hFF, 1'b0, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      send_item(8'hFF, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'h5A, 1'b0, 1'b1);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hA5, 1'b0, 1'b1);
      send_item(8'h11, 1'b1, 1'b0);
      send_item(8'hFF, 1'b0, 1'b0);
      send_item(8'h22, 1'b1, 1'b1);
      drain_results();

      while (sent_items < 1450) begin
         send_message(pick_length(), $urandom_range(3, 0) == 0);
         if ($urandom_range(9, 0) == 0) drain_results();
      end

      drain_results();
      repeat (300) @(negedge clock);
      if (board.mismatches == 0) begin
         $display("sha1_stream_hash_core verification clean");
      end else begin
         $display("sha1_stream_hash_core verification failed");
      end
      $finish;
   end

   initial begin : rsp_stall_pattern
      int span;
      int style;
      forever begin
         style = $urandom_range(3, 0);
         span  = $urandom_range(200, 10);
         repeat (span) begin
            @(negedge clock);
            case (style)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(1, 0) == 0);
               2: rsp_stall <= ($urandom_range(7, 0) != 0);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_digest(rsp_data);
   end

   initial begin : watchdog
      #2_000_000;
      $display("sha1_stream_hash_core verification failed");
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
hw/rtl/sha1sh_pkg.sv
hw/rtl/sha1_stream_hash_core.sv
test/tb_sha1_stream_hash_core.sv
